// ===== hw/rtl/dafu_pkg.sv =====
// ----------------------------------------------------------------------------
// dafu_pkg
// Shared sizes, command and status types of the duplicate address filter.
// ----------------------------------------------------------------------------
package dafu_pkg;

  // set size and stored address width
  localparam int SET_DEPTH = 64;
  localparam int ADDR_BITS = 64;

  // fixed field widths of the channels
  localparam int ADDR_W  = 64;
  localparam int BATCH_W = 7;
  localparam int UCNT_W  = 7;

  // derived widths
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > BATCH_W) ? CNT_W : BATCH_W;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dafu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } dafu_sts_t;

endpackage

// ===== hw/rtl/dafu_if.sv =====
// ----------------------------------------------------------------------------
// dafu_in_if / dafu_out_if
// Valid/ready channels carrying address beats in and filter results out.
// ----------------------------------------------------------------------------
interface dafu_in_if;
  logic                        valid;
  logic                        ready;
  logic                        new_batch;
  logic [dafu_pkg::BATCH_W-1:0] batch_size;
  logic [dafu_pkg::ADDR_W-1:0]  address;

  modport source (output valid, new_batch, batch_size, address, input ready);
  modport sink   (input valid, new_batch, batch_size, address, output ready);
endinterface

interface dafu_out_if;
  logic                        valid;
  logic                        ready;
  logic                        duplicate;
  logic [dafu_pkg::UCNT_W-1:0] unique_count;
  logic                        overflow;

  modport source (output valid, duplicate, unique_count, overflow, input ready);
  modport sink   (input valid, duplicate, unique_count, overflow, output ready);
endinterface

// ===== hw/rtl/dafu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dafu_ctrl
// Sequencer: takes a beat, runs the set scan, then commits the result.
// ----------------------------------------------------------------------------
module dafu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dafu_pkg::dafu_sts_t sts,
  output dafu_pkg::dafu_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } dafu_state_t;

  dafu_state_t state_r;
  dafu_state_t state_nxt;

  // handshake and commands
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.scan   = (state_r == ST_SCAN);
    cmd.commit = (state_r == ST_DONE) && !sts.out_busy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // accepted beat always starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN))
    else $error("accepted beat did not start a scan");

  // a commit returns the sequencer to idle
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (in_ready && !cmd.scan))
    else $error("commit did not return to idle");

endmodule

// ===== hw/rtl/dafu_dp.sv =====
// ----------------------------------------------------------------------------
// dafu_dp
// Datapath: address set memory, scan compare, counters and output register.
// ----------------------------------------------------------------------------
module dafu_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dafu_pkg::dafu_cmd_t           cmd,
  output dafu_pkg::dafu_sts_t           sts,
  input  logic                          in_new_batch,
  input  logic [dafu_pkg::BATCH_W-1:0]  in_batch_size,
  input  logic [dafu_pkg::ADDR_W-1:0]   in_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_duplicate,
  output logic [dafu_pkg::UCNT_W-1:0]   out_unique_count,
  output logic                          out_overflow
);

  // set storage
  logic [dafu_pkg::ADDR_BITS-1:0] set_mem_r [dafu_pkg::SET_DEPTH];
  logic [dafu_pkg::ADDR_BITS-1:0] rd_data_r;
  logic [dafu_pkg::IDX_W-1:0]     rd_idx;
  logic [dafu_pkg::IDX_W-1:0]     wr_idx;
  logic                           mem_we;

  // item and batch state
  logic [dafu_pkg::ADDR_BITS-1:0] addr_r;
  logic [dafu_pkg::CNT_W-1:0]     count_r;
  logic [dafu_pkg::BATCH_W-1:0]   limit_r;
  logic [dafu_pkg::CNT_W-1:0]     scan_idx_r;
  logic                           rd_vld_r;
  logic                           hit_r;

  // output register
  logic                           out_valid_r;
  logic                           out_dup_r;
  logic                           out_ovf_r;
  logic [dafu_pkg::UCNT_W-1:0]    out_cnt_r;

  logic [dafu_pkg::CMP_W-1:0]     limit_ext;
  logic [dafu_pkg::CMP_W-1:0]     cap;
  logic                           full;
  logic                           store;
  logic                           scan_more;
  logic [dafu_pkg::CNT_W-1:0]     count_inc;

  // capacity is the batch limit clipped to the set depth
  always_comb begin
    limit_ext = dafu_pkg::CMP_W'(limit_r);
    cap       = (limit_ext > dafu_pkg::CMP_W'(dafu_pkg::SET_DEPTH)) ?
                dafu_pkg::CMP_W'(dafu_pkg::SET_DEPTH) : limit_ext;
    full      = (dafu_pkg::CMP_W'(count_r) >= cap);
    store     = cmd.commit && !hit_r && !full;
    count_inc = count_r + dafu_pkg::CNT_W'(1);
    scan_more = (scan_idx_r < count_r);
    rd_idx    = scan_idx_r[dafu_pkg::IDX_W-1:0];
    wr_idx    = count_r[dafu_pkg::IDX_W-1:0];
    mem_we    = store;
  end

  // status back to the sequencer
  always_comb begin
    sts.scan_done = !scan_more && !rd_vld_r;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) set_mem_r[wr_idx] <= addr_r;
    rd_data_r <= set_mem_r[rd_idx];
  end

  // latch the beat's address
  always_ff @(posedge clk) begin
    if (cmd.load) addr_r <= in_address[dafu_pkg::ADDR_BITS-1:0];
  end

  // batch counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= '0;
    end else if (cmd.load && in_new_batch) begin
      count_r <= '0;
      limit_r <= in_batch_size;
    end else if (store) begin
      count_r <= count_inc;
    end
  end

  // scan: one read issued and one entry compared per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.load) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld_r <= scan_more;
      if (scan_more) scan_idx_r <= scan_idx_r + dafu_pkg::CNT_W'(1);
      if (rd_vld_r && (rd_data_r == addr_r)) hit_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_dup_r <= hit_r;
      out_ovf_r <= !hit_r && full;
      out_cnt_r <= dafu_pkg::UCNT_W'(store ? count_inc : count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duplicate    = out_dup_r;
  assign out_overflow     = out_ovf_r;
  assign out_unique_count = out_cnt_r;

  // count never passes the set depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    dafu_pkg::CMP_W'(count_r) <= dafu_pkg::CMP_W'(dafu_pkg::SET_DEPTH))
    else $error("stored count beyond set depth");

  // a result is never both duplicate and overflow
  a_dup_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_dup_r && out_ovf_r))
    else $error("duplicate and overflow both set");

  // a stored address raises the count by one
  a_store_inc: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> (count_r == $past(count_inc)))
    else $error("count not raised after store");

  // no commit while the scan still has entries to compare
  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!scan_more && !rd_vld_r))
    else $error("commit before scan finished");

endmodule

// ===== hw/rtl/duplicate_address_filter_unit.sv =====
// ----------------------------------------------------------------------------
// duplicate_address_filter_unit
// Batch duplicate filter: a stored address set scanned for each beat.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   new_batch, batch_size[6:0], address[63:0]
//   out_ch    out  valid/ready   duplicate, unique_count[6:0], overflow
//
// each beat is compared with the n addresses stored in the batch by a scan of the set
// memory, one entry per cycle; the result is registered once the scan ends and commits
// a new beat is taken only after the previous one's result has been committed
// reset clears counters and control; set memory contents are not cleared
// a stalled result holds the unit in its commit step, the next beat is
// taken while the previous result still waits in the output register
module duplicate_address_filter_unit (
  input logic       clk,
  input logic       rst_n,
  dafu_in_if.sink   in_ch,
  dafu_out_if.source out_ch
);

  dafu_pkg::dafu_cmd_t cmd;
  dafu_pkg::dafu_sts_t sts;

  // sequencer
  dafu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  dafu_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_new_batch     (in_ch.new_batch),
    .in_batch_size    (in_ch.batch_size),
    .in_address       (in_ch.address),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_duplicate    (out_ch.duplicate),
    .out_unique_count (out_ch.unique_count),
    .out_overflow     (out_ch.overflow)
  );

endmodule
